// File: hw/rtl/stt_pkg.sv
package stt_pkg;

    localparam int SLOTS_DEF       = 16;
    localparam int HANDLE_BITS_DEF = 16;
    localparam int TIME_W          = 32;
    localparam int OUT_HANDLE_W    = 16;

    typedef enum logic [1:0] {
        ACT_ONESHOT = 2'd0,
        ACT_RECUR   = 2'd1,
        ACT_CANCEL  = 2'd2,
        ACT_POLL    = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        KIND_SCHED  = 2'd0,
        KIND_CANCEL = 2'd1,
        KIND_FIRED  = 2'd2,
        KIND_IDLE   = 2'd3
    } reply_kind_t;

    // per-cycle orders to every cell of the row
    typedef struct packed {
        logic rotate;   // every cell takes its upper neighbour
        logic compact;  // cells at or above a hole take their upper neighbour
        logic sched;    // first empty cell loads the new entry
    } cell_ctl_t;

endpackage

// File: hw/rtl/stt_cell.sv
module stt_cell #(
    parameter int HANDLE_BITS = stt_pkg::HANDLE_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  stt_pkg::cell_ctl_t          ctl,
    input  logic                        up_valid,
    input  logic [HANDLE_BITS-1:0]      up_handle,
    input  logic [stt_pkg::TIME_W-1:0]  up_interval,
    input  logic [stt_pkg::TIME_W-1:0]  up_start,
    input  logic                        up_repeats,
    input  logic                        below_valid,
    input  logic                        hole_in,
    input  logic [HANDLE_BITS-1:0]      new_handle,
    input  logic [stt_pkg::TIME_W-1:0]  new_interval,
    input  logic [stt_pkg::TIME_W-1:0]  new_start,
    input  logic                        new_repeats,
    output logic                        valid,
    output logic [HANDLE_BITS-1:0]      handle,
    output logic [stt_pkg::TIME_W-1:0]  interval,
    output logic [stt_pkg::TIME_W-1:0]  start_time,
    output logic                        repeats,
    output logic                        hole_out
);
    import stt_pkg::*;

    logic                   valid_reg;
    logic                   valid_next;
    logic [HANDLE_BITS-1:0] handle_reg;
    logic [HANDLE_BITS-1:0] handle_next;
    logic [TIME_W-1:0]      interval_reg;
    logic [TIME_W-1:0]      interval_next;
    logic [TIME_W-1:0]      start_reg;
    logic [TIME_W-1:0]      start_next;
    logic                   repeats_reg;
    logic                   repeats_next;
    logic                   take;
    logic                   load;

    assign hole_out = hole_in | ~valid_reg;
    assign take     = ctl.rotate | (ctl.compact & (hole_in | ~valid_reg));
    assign load     = ctl.sched & ~valid_reg & below_valid;

    always_comb
    begin
        valid_next    = valid_reg;
        handle_next   = handle_reg;
        interval_next = interval_reg;
        start_next    = start_reg;
        repeats_next  = repeats_reg;
        if (take)
        begin
            valid_next    = up_valid;
            handle_next   = up_handle;
            interval_next = up_interval;
            start_next    = up_start;
            repeats_next  = up_repeats;
        end
        else if (load)
        begin
            valid_next    = 1'b1;
            handle_next   = new_handle;
            interval_next = new_interval;
            start_next    = new_start;
            repeats_next  = new_repeats;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        handle_reg   <= handle_next;
        interval_reg <= interval_next;
        start_reg    <= start_next;
        repeats_reg  <= repeats_next;
    end

    assign valid      = valid_reg;
    assign handle     = handle_reg;
    assign interval   = interval_reg;
    assign start_time = start_reg;
    assign repeats    = repeats_reg;

endmodule

// File: hw/rtl/stt_ctrl.sv
module stt_ctrl #(
    parameter int SLOTS       = stt_pkg::SLOTS_DEF,
    parameter int HANDLE_BITS = stt_pkg::HANDLE_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [1:0]                       action,
    input  logic [stt_pkg::OUT_HANDLE_W-1:0] target_handle,
    input  logic [stt_pkg::TIME_W-1:0]       now_ms,
    input  logic                             full,
    input  logic                             head_valid,
    input  logic [HANDLE_BITS-1:0]           head_handle,
    input  logic [stt_pkg::TIME_W-1:0]       head_interval,
    input  logic [stt_pkg::TIME_W-1:0]       head_start,
    input  logic                             head_repeats,
    output logic                             busy,
    output stt_pkg::cell_ctl_t               ctl,
    output logic [HANDLE_BITS-1:0]           new_handle,
    output logic                             tail_valid,
    output logic [stt_pkg::TIME_W-1:0]       tail_start,
    output logic                             strobe,
    output logic [1:0]                       reply_kind,
    output logic [stt_pkg::OUT_HANDLE_W-1:0] result_handle,
    output logic                             ok,
    output logic                             last
);
    import stt_pkg::*;

    localparam int CNT_W = $clog2(SLOTS);
    localparam int CMP_W = (HANDLE_BITS > OUT_HANDLE_W) ? HANDLE_BITS : OUT_HANDLE_W;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_ROT  = 4'b0010,
        ST_CMP  = 4'b0100,
        ST_FIN  = 4'b1000
    } ctrl_state_t;

    ctrl_state_t              state_reg,   state_next;
    logic [CNT_W-1:0]         cnt_reg,     cnt_next;
    logic [HANDLE_BITS-1:0]   counter_reg, counter_next;
    logic                     flag_reg,    flag_next;
    logic                     removed_reg, removed_next;
    logic                     strobe_reg,  strobe_next;
    logic                     poll_reg,    poll_next;
    logic [TIME_W-1:0]        now_reg,     now_next;
    logic [OUT_HANDLE_W-1:0]  target_reg,  target_next;
    logic [OUT_HANDLE_W-1:0]  pend_reg,    pend_next;
    reply_kind_t              kind_reg,    kind_next;
    logic [OUT_HANDLE_W-1:0]  rhandle_reg, rhandle_next;
    logic                     ok_reg,      ok_next;
    logic                     last_reg,    last_next;

    logic accept;
    logic is_sched;
    logic rotating;
    logic match;
    logic due;
    logic hit;
    logic drop;
    logic cnt_last;
    logic cmp_last;

    always_comb
    begin
        is_sched = 1'b0;
        case (action) inside
            ACT_ONESHOT, ACT_RECUR: is_sched = 1'b1;
            default:                is_sched = 1'b0;
        endcase
    end

    assign accept   = start && (state_reg == ST_IDLE);
    assign rotating = (state_reg == ST_ROT);
    assign busy     = (state_reg != ST_IDLE);

    assign ctl.sched   = accept && is_sched;
    assign ctl.rotate  = rotating;
    assign ctl.compact = (state_reg == ST_CMP);

    assign new_handle = counter_reg;

    // wide compare so that handles wider than the reply field must carry zero high bits
    assign match = (CMP_W'(head_handle) == CMP_W'(target_reg));
    assign due   = (TIME_W'(now_reg - head_start) >= head_interval);
    assign hit   = rotating && head_valid && (poll_reg ? due : match);
    assign drop  = hit && (!poll_reg || !head_repeats);

    assign tail_valid = rotating && head_valid && !drop;
    assign tail_start = (hit && poll_reg) ? now_reg : head_start;

    assign cnt_last = (cnt_reg == CNT_W'(SLOTS - 1));
    assign cmp_last = (cnt_reg == CNT_W'(SLOTS - 2));

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        counter_next = counter_reg;
        flag_next    = flag_reg;
        removed_next = removed_reg;
        strobe_next  = 1'b0;
        poll_next    = poll_reg;
        now_next     = now_reg;
        target_next  = target_reg;
        pend_next    = pend_reg;
        kind_next    = kind_reg;
        rhandle_next = rhandle_reg;
        ok_next      = ok_reg;
        last_next    = last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (is_sched)
                    begin
                        strobe_next = 1'b1;
                        kind_next   = KIND_SCHED;
                        last_next   = 1'b1;
                        if (full)
                        begin
                            rhandle_next = '0;
                            ok_next      = 1'b0;
                        end
                        else
                        begin
                            rhandle_next = OUT_HANDLE_W'(counter_reg);
                            ok_next      = 1'b1;
                            counter_next = counter_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        state_next   = ST_ROT;
                        cnt_next     = '0;
                        poll_next    = (action == ACT_POLL);
                        now_next     = now_ms;
                        target_next  = target_handle;
                        flag_next    = 1'b0;
                        removed_next = 1'b0;
                    end
                end
            end
            ST_ROT:
            begin
                cnt_next     = cnt_reg + 1'b1;
                flag_next    = flag_reg | hit;
                removed_next = removed_reg | drop;
                if (hit && poll_reg)
                begin
                    pend_next = OUT_HANDLE_W'(head_handle);
                    if (flag_reg)
                    begin
                        strobe_next  = 1'b1;
                        kind_next    = KIND_FIRED;
                        rhandle_next = pend_reg;
                        ok_next      = 1'b1;
                        last_next    = 1'b0;
                    end
                end
                if (cnt_last)
                begin
                    cnt_next   = '0;
                    state_next = (removed_reg || drop) ? ST_CMP : ST_FIN;
                end
            end
            ST_CMP:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cmp_last)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                state_next  = ST_IDLE;
                strobe_next = 1'b1;
                last_next   = 1'b1;
                if (!poll_reg)
                begin
                    kind_next    = KIND_CANCEL;
                    rhandle_next = target_reg;
                    ok_next      = flag_reg;
                end
                else if (flag_reg)
                begin
                    kind_next    = KIND_FIRED;
                    rhandle_next = pend_reg;
                    ok_next      = 1'b1;
                end
                else
                begin
                    kind_next    = KIND_IDLE;
                    rhandle_next = '0;
                    ok_next      = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            counter_reg <= '0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            counter_reg <= counter_next;
            strobe_reg  <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        flag_reg    <= flag_next;
        removed_reg <= removed_next;
        poll_reg    <= poll_next;
        now_reg     <= now_next;
        target_reg  <= target_next;
        pend_reg    <= pend_next;
        kind_reg    <= kind_next;
        rhandle_reg <= rhandle_next;
        ok_reg      <= ok_next;
        last_reg    <= last_next;
    end

    assign strobe        = strobe_reg;
    assign reply_kind    = kind_reg;
    assign result_handle = rhandle_reg;
    assign ok            = ok_reg;
    assign last          = last_reg;

    a_ctl_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctl.rotate, ctl.compact, ctl.sched}))
        else $error("more than one cell order at once");

    a_idle_still: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> !(ctl.rotate || ctl.compact))
        else $error("row moves while idle");

    a_cmp_no_live: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.compact |-> !tail_valid)
        else $error("live entry fed into the row during compaction");

    a_mid_fired: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !last) |-> (reply_kind == KIND_FIRED))
        else $error("non-final word that is not a fired timer");

    a_sched_reply: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (action == ACT_ONESHOT || action == ACT_RECUR))
        |=> (strobe && last && reply_kind == KIND_SCHED))
        else $error("schedule without its reply");

endmodule

// File: hw/rtl/software_timer_table.sv
// Ordered table of one-shot and recurring timers.
//
// Command channel: an item (action, delay_ms, target_handle, now_ms) is taken
// at a rising edge with start high and busy low. Result channel: each word
// stands on reply_kind/result_handle/ok/last for one cycle, flagged by strobe;
// the receiver cannot stall it, so nothing here waits on the far side.
//
// Schedule: busy stays low, the reply word follows in the cycle after the item.
// Cancel and poll: the whole row of SLOTS cells rotates once past the head
// cell, where each entry is tested and either written back at the tail or
// dropped. If anything was dropped, compaction steps close the gaps. A final
// state issues the last word. So busy is held through the rotation, the
// compaction if any and the final state; fired words stream out during the
// rotation, at most one a cycle, the last one after it.
//
// Reset: all cells empty, handle counter zero, no word pending.
module software_timer_table #(
    parameter int SLOTS       = stt_pkg::SLOTS_DEF,
    parameter int HANDLE_BITS = stt_pkg::HANDLE_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [1:0]                       action,
    input  logic [stt_pkg::TIME_W-1:0]       delay_ms,
    input  logic [stt_pkg::OUT_HANDLE_W-1:0] target_handle,
    input  logic [stt_pkg::TIME_W-1:0]       now_ms,
    output logic                             strobe,
    output logic [1:0]                       reply_kind,
    output logic [stt_pkg::OUT_HANDLE_W-1:0] result_handle,
    output logic                             ok,
    output logic                             last
);
    import stt_pkg::*;

    cell_ctl_t              ctl;
    logic [SLOTS-1:0]       cell_valid;
    logic [HANDLE_BITS-1:0] cell_handle   [SLOTS];
    logic [TIME_W-1:0]      cell_interval [SLOTS];
    logic [TIME_W-1:0]      cell_start    [SLOTS];
    logic [SLOTS-1:0]       cell_repeats;
    // hole_chain[i]: some cell below i is empty; the top tap says the table has room
    logic [SLOTS:0]         hole_chain;
    logic [HANDLE_BITS-1:0] new_handle;
    logic                   tail_valid;
    logic [TIME_W-1:0]      tail_start;
    logic                   full;

    assign hole_chain[0] = 1'b0;
    assign full          = ~hole_chain[SLOTS];

    // Row of cells: cell 0 is the head, the oldest entry. Each cell hands its
    // entry to the cell below when the row moves; the top cell is fed by the
    // controller with the head entry after its test.
    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        logic                   up_valid;
        logic [HANDLE_BITS-1:0] up_handle;
        logic [TIME_W-1:0]      up_interval;
        logic [TIME_W-1:0]      up_start;
        logic                   up_repeats;
        logic                   below_valid;

        if (i == SLOTS - 1)
        begin : g_top
            assign up_valid    = tail_valid;
            assign up_handle   = cell_handle[0];
            assign up_interval = cell_interval[0];
            assign up_start    = tail_start;
            assign up_repeats  = cell_repeats[0];
        end
        else
        begin : g_mid
            assign up_valid    = cell_valid[i+1];
            assign up_handle   = cell_handle[i+1];
            assign up_interval = cell_interval[i+1];
            assign up_start    = cell_start[i+1];
            assign up_repeats  = cell_repeats[i+1];
        end

        // a new entry lands in the first empty cell above a filled one, or in the head cell of an empty table
        if (i == 0)
        begin : g_head
            assign below_valid = 1'b1;
        end
        else
        begin : g_rest
            assign below_valid = cell_valid[i-1];
        end

        stt_cell #(
            .HANDLE_BITS (HANDLE_BITS)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctl          (ctl),
            .up_valid     (up_valid),
            .up_handle    (up_handle),
            .up_interval  (up_interval),
            .up_start     (up_start),
            .up_repeats   (up_repeats),
            .below_valid  (below_valid),
            .hole_in      (hole_chain[i]),
            .new_handle   (new_handle),
            .new_interval (delay_ms),
            .new_start    (now_ms),
            .new_repeats  (action == ACT_RECUR),
            .valid        (cell_valid[i]),
            .handle       (cell_handle[i]),
            .interval     (cell_interval[i]),
            .start_time   (cell_start[i]),
            .repeats      (cell_repeats[i]),
            .hole_out     (hole_chain[i+1])
        );
    end

    // Sequencer: handle counter, head test, word assembly.
    stt_ctrl #(
        .SLOTS       (SLOTS),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .action        (action),
        .target_handle (target_handle),
        .now_ms        (now_ms),
        .full          (full),
        .head_valid    (cell_valid[0]),
        .head_handle   (cell_handle[0]),
        .head_interval (cell_interval[0]),
        .head_start    (cell_start[0]),
        .head_repeats  (cell_repeats[0]),
        .busy          (busy),
        .ctl           (ctl),
        .new_handle    (new_handle),
        .tail_valid    (tail_valid),
        .tail_start    (tail_start),
        .strobe        (strobe),
        .reply_kind    (reply_kind),
        .result_handle (result_handle),
        .ok            (ok),
        .last          (last)
    );

endmodule

// File: bench/tb_top.sv
module tb_top;
    import stt_pkg::*;

    localparam int SLOTS      = SLOTS_DEF;
    localparam int HW         = OUT_HANDLE_W;
    localparam int WATCHDOG   = 4000;
    localparam int RAND_CMDS  = 335;
    localparam int SHOW_LIMIT = 10;

    // One command word as the sender presents it.
    typedef struct {
        action_t       act;
        logic [31:0]   delay;
        logic [HW-1:0] target;
        logic [31:0]   now;
        bit            drain;    // hold back until every reply word is home
    } cmd_t;

    // One live timer, kept in schedule order.
    typedef struct {
        logic [HW-1:0] handle;
        logic [31:0]   interval;
        logic [31:0]   start_ms;
        bit            repeats;
    } timer_t;

    // One reply word as the block should emit it.
    typedef struct {
        reply_kind_t   kind;
        logic [HW-1:0] handle;
        logic          ok;
        logic          last;
    } reply_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          start = 1'b0;
    logic          busy;
    logic [1:0]    action = ACT_POLL;
    logic [31:0]   delay_ms = '0;
    logic [HW-1:0] target_handle = '0;
    logic [31:0]   now_ms = '0;
    logic          strobe;
    logic [1:0]    reply_kind;
    logic [HW-1:0] result_handle;
    logic          ok;
    logic          last;

    // Commands waiting for the driver, and reply words still owed by the block.
    cmd_t          pending_q[$];
    reply_t        reply_q[$];

    // Shadow of the timer table, updated as each command word is taken.
    timer_t        timer_list[$];
    logic [HW-1:0] next_handle = '0;

    int            mismatch_count = 0;
    bit            took_cmd = 1'b0;
    int            burst_left = 4;
    int            gap_left = 0;
    int            idle_cycles = 0;

    software_timer_table #(
        .SLOTS       (SLOTS),
        .HANDLE_BITS (HANDLE_BITS_DEF)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .action        (action),
        .delay_ms      (delay_ms),
        .target_handle (target_handle),
        .now_ms        (now_ms),
        .strobe        (strobe),
        .reply_kind    (reply_kind),
        .result_handle (result_handle),
        .ok            (ok),
        .last          (last)
    );

    always #2 clk = ~clk;

    function automatic void owe_reply(reply_kind_t kind, logic [HW-1:0] handle,
                                      logic ok_bit, logic last_bit);
        reply_t r;
        r.kind   = kind;
        r.handle = handle;
        r.ok     = ok_bit;
        r.last   = last_bit;
        reply_q = {reply_q, r};
    endfunction

    // Advance the shadow table by one command and queue the reply words it owes.
    function automatic void apply_timer_cmd(action_t act, logic [31:0] delay,
                                            logic [HW-1:0] target, logic [31:0] now);
        timer_t      t;
        bit          found;
        int          i;
        int          fired;
        logic [31:0] elapsed;
        case (act)
            ACT_ONESHOT, ACT_RECUR:
            begin
                // a full table refuses the timer and burns no handle
                if (timer_list.size() >= SLOTS)
                    owe_reply(KIND_SCHED, '0, 1'b0, 1'b1);
                else
                begin
                    t.handle   = next_handle;
                    t.interval = delay;
                    t.start_ms = now;
                    t.repeats  = (act == ACT_RECUR);
                    timer_list = {timer_list, t};
                    owe_reply(KIND_SCHED, next_handle, 1'b1, 1'b1);
                    next_handle = next_handle + 1'b1;
                end
            end
            ACT_CANCEL:
            begin
                // drop every match: handles repeat once the counter has wrapped
                found = 1'b0;
                i = 0;
                while (i < timer_list.size())
                begin
                    if (timer_list[i].handle == target)
                    begin
                        timer_list.delete(i);
                        found = 1'b1;
                    end
                    else
                        i++;
                end
                owe_reply(KIND_CANCEL, target, found, 1'b1);
            end
            default:
            begin
                // walk in order; recurring timers restart, one-shots close up
                fired = 0;
                i = 0;
                while (i < timer_list.size())
                begin
                    elapsed = now - timer_list[i].start_ms;
                    if (elapsed >= timer_list[i].interval)
                    begin
                        owe_reply(KIND_FIRED, timer_list[i].handle, 1'b1, 1'b0);
                        fired++;
                        if (timer_list[i].repeats)
                        begin
                            timer_list[i].start_ms = now;
                            i++;
                        end
                        else
                            timer_list.delete(i);
                    end
                    else
                        i++;
                end
                if (fired == 0)
                    owe_reply(KIND_IDLE, '0, 1'b0, 1'b1);
                else
                    reply_q[reply_q.size() - 1].last = 1'b1;
            end
        endcase
    endfunction

    function automatic void note_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= SHOW_LIMIT)
            $display("mismatch at %0t: %s", $realtime, what);
    endfunction

    function automatic void queue_cmd(action_t act, logic [31:0] delay,
                                      logic [HW-1:0] target, logic [31:0] now,
                                      bit drain);
        cmd_t c;
        c.act    = act;
        c.delay  = delay;
        c.target = target;
        c.now    = now;
        c.drain  = drain;
        pending_q = {pending_q, c};
    endfunction

    // Monitor: check the reply word first, then take in any command word, so an
    // item's own replies are never confused with the ones already owed.
    always @(posedge clk)
    begin
        reply_t want;
        took_cmd = 1'b0;
        if (rst_n)
        begin
            if (strobe)
            begin
                if (reply_q.size() == 0)
                    note_mismatch($sformatf("unexpected word kind %0d handle %h ok %b last %b",
                                            reply_kind, result_handle, ok, last));
                else
                begin
                    want = reply_q.pop_front();
                    if (reply_kind !== want.kind || result_handle !== want.handle ||
                        ok !== want.ok || last !== want.last)
                        note_mismatch($sformatf(
                            "kind %0d/%0d handle %h/%h ok %b/%b last %b/%b (expected/actual)",
                            want.kind, reply_kind, want.handle, result_handle,
                            want.ok, ok, want.last, last));
                end
            end
            if (start && !busy)
            begin
                apply_timer_cmd(action_t'(action), delay_ms, target_handle, now_ms);
                took_cmd = 1'b1;
            end
        end
    end

    // Driver: hold a word until it is taken, then either present the next one or
    // idle. Bursts of random length alternate with random gaps; idle inputs carry
    // junk so that the block is seen to ignore them.
    always @(negedge clk)
    begin
        if (took_cmd)
            pending_q.delete(0);
        if (!rst_n)
            start <= 1'b0;
        else if (!(start && !took_cmd))
        begin
            if (pending_q.size() != 0 && gap_left == 0 &&
                !(pending_q[0].drain && reply_q.size() != 0))
            begin
                start         <= 1'b1;
                action        <= pending_q[0].act;
                delay_ms      <= pending_q[0].delay;
                target_handle <= pending_q[0].target;
                now_ms        <= pending_q[0].now;
                if (burst_left > 1)
                    burst_left--;
                else
                begin
                    // a quarter of the bursts run straight on with no gap
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                             : $urandom_range(1, 12);
                end
            end
            else
            begin
                start         <= 1'b0;
                action        <= 2'($urandom);
                delay_ms      <= $urandom;
                target_handle <= HW'($urandom);
                now_ms        <= $urandom;
                if (gap_left > 0)
                    gap_left--;
            end
        end
    end

    // Watchdog: end the run when neither side has moved a word for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || strobe)
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        logic [31:0]   gen_now;
        logic [HW-1:0] sched_guess;
        logic [31:0]   delay;
        logic [HW-1:0] target;
        action_t       act;
        int            pick;
        int            n;

        // Directed part: empty table, wrap of the clock, full table.
        gen_now = 32'hFFFF_FFF0;
        queue_cmd(ACT_POLL, 32'h0, '0, 32'h0, 1'b0);              // nothing due
        queue_cmd(ACT_CANCEL, 32'h0, '0, 32'h0, 1'b0);            // not found
        queue_cmd(ACT_ONESHOT, 32'h0, '0, gen_now, 1'b0);         // handle 0, due at once
        queue_cmd(ACT_RECUR, 32'h20, '0, gen_now, 1'b0);          // handle 1
        queue_cmd(ACT_ONESHOT, 32'hFFFF_FFFF, '0, gen_now, 1'b0); // handle 2, never due
        queue_cmd(ACT_POLL, 32'h0, '0, gen_now, 1'b0);            // fires handle 0 only
        queue_cmd(ACT_POLL, 32'h0, '0, 32'h10, 1'b0);             // across the wrap
        queue_cmd(ACT_CANCEL, 32'h0, 16'd2, 32'h10, 1'b0);        // found
        // fill the table, mixing zero, short and extreme intervals
        for (n = 0; n < SLOTS - 1; n++)
        begin
            act   = (n % 3 == 0) ? ACT_RECUR : ACT_ONESHOT;
            delay = (n % 4 == 0) ? 32'h0 : ((n % 5 == 0) ? 32'hFFFF_FFFF : 32'(n * 7));
            queue_cmd(act, delay, '0, 32'h20 + n, 1'b0);
        end
        queue_cmd(ACT_RECUR, 32'h5, '0, 32'h40, 1'b0);            // table full
        queue_cmd(ACT_POLL, 32'h0, '0, 32'h8000_0040, 1'b0);      // many fire at once

        // Random part: mostly well-formed traffic on a moving clock, some junk.
        gen_now     = 32'h100;
        sched_guess = HW'(SLOTS + 2);
        for (n = 0; n < RAND_CMDS; n++)
        begin
            gen_now += ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 40);
            pick = $urandom_range(0, 99);
            case ($urandom_range(0, 9))
                0, 1:    delay = 32'h0;
                8:       delay = $urandom;
                9:       delay = 32'hFFFF_FFFF - $urandom_range(0, 3);
                default: delay = $urandom_range(1, 60);
            endcase
            case ($urandom_range(0, 9))
                7, 8:    target = HW'($urandom);
                9:       target = '1;
                default: target = HW'(sched_guess - $urandom_range(0, 16));
            endcase
            if (pick < 5)
                queue_cmd(action_t'($urandom_range(0, 3)), $urandom, HW'($urandom),
                          $urandom, 1'b0);
            else if (pick < 50)
            begin
                queue_cmd((pick < 30) ? ACT_ONESHOT : ACT_RECUR, delay, '0, gen_now,
                          (n == 0) || ($urandom_range(0, 59) == 0));
                sched_guess++;
            end
            else if (pick < 68)
                queue_cmd(ACT_CANCEL, $urandom, target, gen_now, $urandom_range(0, 59) == 0);
            else
                queue_cmd(ACT_POLL, $urandom, HW'($urandom), gen_now,
                          $urandom_range(0, 59) == 0);
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_q.size() != 0 || reply_q.size() != 0)
            @(posedge clk);
        // let any stray word surface before the verdict
        repeat (2 * SLOTS + 8) @(posedge clk);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
